>>> design/ntcrt_pkg.sv
// shared types and constants for the thermistor conversion pipeline
package ntcrt_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 56;
   localparam int TERM_W      = 62;
   localparam int QUOT_W      = 18;
   localparam int DIV_STAGES  = QUOT_W + 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_A_COEF    = 3'd0,
      CSR_B_COEF    = 3'd1,
      CSR_C_COEF    = 3'd2,
      CSR_INV_T_REF = 3'd3,
      CSR_INV_BETA  = 3'd4,
      CSR_LN_R_REF  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO     = 2'd1,
      ST_SH_BAD   = 2'd2,
      ST_BETA_BAD = 2'd3
   } status_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } side_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic sh_ok;
      logic b_ok;
   } tail_type;

   localparam logic [63:0]       LN2_Q64      = 64'hB17217F7D1CF79AB;
   localparam logic [TERM_W-1:0] TERM_SAT     = 62'h2000_0000_0000_0000;
   localparam logic [63:0]       CENTI_NUM    = 64'd100 << 52;
   localparam logic [17:0]       KELVIN_CENTI = 18'd27315;
   localparam logic [17:0]       TEMP_MAX     = 18'd100000;
   localparam logic [17:0]       Q_MAX        = 18'd127315;
   localparam logic signed [18:0] DIFF_LIM    = 19'sd20000;

endpackage

>>> design/ntcrt_delay.sv
// delay line of registers with a common advance enable
module ntcrt_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            stage_ff[i] <= '0;
         end
      end else if (en) begin
         stage_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign d_out = stage_ff[DEPTH-1];

endmodule

>>> design/ntcrt_log2.sv
// base-2 logarithm by normalisation and one squaring per stage
module ntcrt_log2 #(
   parameter int RB = 24,
   parameter int F  = 24
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RB-1:0] res,
   output logic [F+4:0]  log2q
);

   logic [4:0]  e_in;
   logic [31:0] x_in;
   logic [31:0] x_ff    [F+1];
   logic [4:0]  e_ff    [F+1];
   logic [F-1:0] frac_ff [F+1];

   always_comb begin
      e_in = '0;
      for (int i = 0; i < RB; i++) begin
         if (res[i]) begin
            e_in = 5'(i);
         end
      end
      x_in = 32'(res) << (5'd31 - e_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x_in;
         e_ff[0]    <= e_in;
         frac_ff[0] <= '0;
      end
   end

   for (genvar i = 1; i <= F; i++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] sh;
      assign sq = 64'(x_ff[i-1]) * 64'(x_ff[i-1]);
      assign sh = sq[63:31];
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= sh[32] ? sh[32:1] : sh[31:0];
            e_ff[i]    <= e_ff[i-1];
            frac_ff[i] <= {frac_ff[i-1][F-2:0], sh[32]};
         end
      end
   end

   assign log2q = {e_ff[F], frac_ff[F]};

endmodule

>>> design/ntcrt_mul.sv
// three-stage product from four partial products, shifted right and saturated
module ntcrt_mul #(
   parameter int WA    = 32,
   parameter int WB    = 32,
   parameter int SHIFT = 24
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [WA-1:0]                 a,
   input  logic [WB-1:0]                 b,
   output logic [ntcrt_pkg::TERM_W-1:0] p
);

   localparam int AL = WA / 2;
   localparam int AH = WA - AL;
   localparam int BL = WB / 2;
   localparam int BH = WB - BL;
   localparam int PW = WA + WB;
   localparam int XW = (PW > ntcrt_pkg::TERM_W) ? PW : ntcrt_pkg::TERM_W;

   logic [AL+BL-1:0] pll_ff;
   logic [AL+BH-1:0] plh_ff;
   logic [AH+BL-1:0] phl_ff;
   logic [AH+BH-1:0] phh_ff;
   logic [PW-1:0]    s1_ff;
   logic [PW-1:0]    s2_ff;
   logic [PW-1:0]    full_in;
   logic [XW-1:0]    shifted_in;
   logic [ntcrt_pkg::TERM_W-1:0] p_in;
   logic [ntcrt_pkg::TERM_W-1:0] p_ff;

   always_comb begin
      full_in    = s1_ff + s2_ff;
      shifted_in = XW'(full_in >> SHIFT);
      if (shifted_in > XW'(ntcrt_pkg::TERM_SAT)) begin
         p_in = ntcrt_pkg::TERM_SAT;
      end else begin
         p_in = shifted_in[ntcrt_pkg::TERM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pll_ff <= a[AL-1:0] * b[BL-1:0];
         plh_ff <= a[AL-1:0] * b[WB-1:BL];
         phl_ff <= a[WA-1:AL] * b[BL-1:0];
         phh_ff <= a[WA-1:AL] * b[WB-1:BL];
         s1_ff  <= PW'(pll_ff) + (PW'(plh_ff) << BL);
         s2_ff  <= (PW'(phl_ff) << AL) + (PW'(phh_ff) << (AL + BL));
         p_ff   <= p_in;
      end
   end

   assign p = p_ff;

endmodule

>>> design/ntcrt_div.sv
// restoring divider for the rounded centikelvin quotient, one bit per stage
module ntcrt_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [62:0]                   d,
   output logic [ntcrt_pkg::QUOT_W-1:0] q,
   output logic                          ovf
);

   localparam int QW = ntcrt_pkg::QUOT_W;

   logic [63:0]   n_ff;
   logic [62:0]   dp_ff;
   logic [63:0]   rem_ff [QW+1];
   logic [62:0]   dd_ff  [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          ovf_ff [QW+1];
   logic          ovf_in;

   assign ovf_in = {18'b0, n_ff} >= ({19'b0, dp_ff} << QW);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff      <= ntcrt_pkg::CENTI_NUM + 64'(d >> 1);
         dp_ff     <= d;
         rem_ff[0] <= n_ff;
         dd_ff[0]  <= dp_ff;
         q_ff[0]   <= '0;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_bit
      logic [81:0] dsh;
      logic        ge;
      assign dsh = {19'b0, dd_ff[j]} << (QW - 1 - j);
      assign ge  = {18'b0, rem_ff[j]} >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? rem_ff[j] - dsh[63:0] : rem_ff[j];
            dd_ff[j+1]  <= dd_ff[j];
            q_ff[j+1]   <= {q_ff[j][QW-2:0], ge};
            ovf_ff[j+1] <= ovf_ff[j];
         end
      end
   end

   assign q   = q_ff[QW];
   assign ovf = ovf_ff[QW];

endmodule

>>> design/ntc_resistance_to_temperature.sv
// thermistor resistance to Steinhart-Hart and beta temperatures, pipelined
// throughput: one beat per cycle while the output is not stalled; depth set by the log
// squaring chain and the two restoring dividers
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// synchronous reset clears all valid bits and the coefficient registers to zero
module ntc_resistance_to_temperature #(
   parameter int RES_BITS      = 24,
   parameter int LOG_FRAC_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [RES_BITS-1:0]                   req_resistance_ohm,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [17:0]                    rsp_temp_sh_centi,
   output logic signed [17:0]                    rsp_temp_beta_centi,
   output logic signed [15:0]                    rsp_model_difference,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ntcrt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ntcrt_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int F  = LOG_FRAC_BITS;
   localparam int LW = F + 5;
   localparam int TW = ntcrt_pkg::TERM_W;

   logic [55:0] a_coef_ff, b_coef_ff, c_coef_ff;
   logic [54:0] inv_t_ref_ff, inv_beta_ff;
   logic [28:0] ln_r_ref_ff;

   logic                 en;
   logic                 rsp_valid_ff;
   logic signed [17:0]   tsh_ff, tb_ff;
   logic signed [15:0]   diff_ff;
   logic [1:0]           status_ff;

   ntcrt_pkg::side_type side_in, side_d;
   ntcrt_pkg::tail_type tail_in, tail_d;

   logic [LW-1:0] log2q;
   logic [TW-1:0] ln_p, l2, l3, cterm, bterm_raw, bterm, iterm_raw, iterm;
   logic [LW-1:0] l_q, l_d3, ref_q, dmag_in, dmag_ff;
   logic          dn_in, dn_ff, dn_d;
   logic [55:0]   bmag, cmag;

   logic [63:0]   a_ext, b_s, c_s, i_s, dsh_in, db_in;
   logic [62:0]   dsh_ff, db_ff;
   logic          sh_ok_ff, b_ok_ff;

   logic [17:0]   q_sh, q_b;
   logic          ovf_sh, ovf_b;
   logic signed [17:0] tsh_in, tb_in;
   logic signed [18:0] dif_in;
   logic signed [15:0] diff_in;
   logic [1:0]         status_in;

   function automatic logic signed [17:0] to_centi(input logic [17:0] q, input logic ovf);
      if (ovf || q > ntcrt_pkg::Q_MAX) begin
         return $signed(ntcrt_pkg::TEMP_MAX);
      end
      return $signed(q - ntcrt_pkg::KELVIN_CENTI);
   endfunction

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_coef_ff    <= '0;
         b_coef_ff    <= '0;
         c_coef_ff    <= '0;
         inv_t_ref_ff <= '0;
         inv_beta_ff  <= '0;
         ln_r_ref_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ntcrt_pkg::CSR_A_COEF:    a_coef_ff    <= csr_data;
            ntcrt_pkg::CSR_B_COEF:    b_coef_ff    <= csr_data;
            ntcrt_pkg::CSR_C_COEF:    c_coef_ff    <= csr_data;
            ntcrt_pkg::CSR_INV_T_REF: inv_t_ref_ff <= csr_data[54:0];
            ntcrt_pkg::CSR_INV_BETA:  inv_beta_ff  <= csr_data[54:0];
            ntcrt_pkg::CSR_LN_R_REF:  ln_r_ref_ff  <= csr_data[28:0];
            default: ;
         endcase
      end
   end

   // coefficient magnitudes; user keeps them stable while beats are in flight, unchecked
   assign bmag = b_coef_ff[55] ? (~b_coef_ff + 56'd1) : b_coef_ff;
   assign cmag = c_coef_ff[55] ? (~c_coef_ff + 56'd1) : c_coef_ff;

   assign side_in.valid = req_valid;
   assign side_in.zero  = (req_resistance_ohm == '0);

   ntcrt_delay #(.WIDTH($bits(ntcrt_pkg::side_type)), .DEPTH(F + 14)) u_side (
      .clock(clock), .reset(reset), .en(en), .d_in(side_in), .d_out(side_d)
   );

   ntcrt_log2 #(.RB(RES_BITS), .F(F)) u_log2 (
      .clock(clock), .en(en), .res(req_resistance_ohm), .log2q(log2q)
   );

   ntcrt_mul #(.WA(LW), .WB(64), .SHIFT(64)) u_mul_ln (
      .clock(clock), .en(en), .a(log2q), .b(ntcrt_pkg::LN2_Q64), .p(ln_p)
   );
   assign l_q = ln_p[LW-1:0];

   // cube of ln r
   ntcrt_mul #(.WA(LW), .WB(LW), .SHIFT(F)) u_mul_ll (
      .clock(clock), .en(en), .a(l_q), .b(l_q), .p(l2)
   );
   ntcrt_delay #(.WIDTH(LW), .DEPTH(3)) u_l_d3 (
      .clock(clock), .reset(reset), .en(en), .d_in(l_q), .d_out(l_d3)
   );
   ntcrt_mul #(.WA(TW), .WB(LW), .SHIFT(F)) u_mul_l3 (
      .clock(clock), .en(en), .a(l2), .b(l_d3), .p(l3)
   );
   ntcrt_mul #(.WA(56), .WB(TW), .SHIFT(F)) u_mul_c (
      .clock(clock), .en(en), .a(cmag), .b(l3), .p(cterm)
   );

   ntcrt_mul #(.WA(56), .WB(LW), .SHIFT(F)) u_mul_b (
      .clock(clock), .en(en), .a(bmag), .b(l_q), .p(bterm_raw)
   );
   ntcrt_delay #(.WIDTH(TW), .DEPTH(6)) u_b_d6 (
      .clock(clock), .reset(reset), .en(en), .d_in(bterm_raw), .d_out(bterm)
   );

   // ln r_ref in the same scale as ln r
   if (F >= 24) begin : g_ref_up
      assign ref_q = LW'(ln_r_ref_ff) << (F - 24);
   end else begin : g_ref_dn
      assign ref_q = LW'(ln_r_ref_ff >> (24 - F));
   end

   assign dn_in   = ref_q > l_q;
   assign dmag_in = dn_in ? ref_q - l_q : l_q - ref_q;

   always_ff @(posedge clock) begin
      if (en) begin
         dmag_ff <= dmag_in;
         dn_ff   <= dn_in;
      end
   end

   ntcrt_mul #(.WA(55), .WB(LW), .SHIFT(F)) u_mul_i (
      .clock(clock), .en(en), .a(inv_beta_ff), .b(dmag_ff), .p(iterm_raw)
   );
   ntcrt_delay #(.WIDTH(TW), .DEPTH(5)) u_i_d5 (
      .clock(clock), .reset(reset), .en(en), .d_in(iterm_raw), .d_out(iterm)
   );
   ntcrt_delay #(.WIDTH(1), .DEPTH(8)) u_dn_d8 (
      .clock(clock), .reset(reset), .en(en), .d_in(dn_ff), .d_out(dn_d)
   );

   // reciprocal denominators
   always_comb begin
      a_ext  = {{8{a_coef_ff[55]}}, a_coef_ff};
      b_s    = b_coef_ff[55] ? 64'd0 - {2'b0, bterm} : {2'b0, bterm};
      c_s    = c_coef_ff[55] ? 64'd0 - {2'b0, cterm} : {2'b0, cterm};
      i_s    = dn_d ? 64'd0 - {2'b0, iterm} : {2'b0, iterm};
      dsh_in = a_ext + b_s + c_s;
      db_in  = {9'b0, inv_t_ref_ff} + i_s;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dsh_ff   <= dsh_in[62:0];
         db_ff    <= db_in[62:0];
         sh_ok_ff <= !dsh_in[63] && (dsh_in != 64'd0);
         b_ok_ff  <= !db_in[63] && (db_in != 64'd0);
      end
   end

   ntcrt_div u_div_sh (
      .clock(clock), .en(en), .d(dsh_ff), .q(q_sh), .ovf(ovf_sh)
   );
   ntcrt_div u_div_beta (
      .clock(clock), .en(en), .d(db_ff), .q(q_b), .ovf(ovf_b)
   );

   assign tail_in.valid = side_d.valid;
   assign tail_in.zero  = side_d.zero;
   assign tail_in.sh_ok = sh_ok_ff;
   assign tail_in.b_ok  = b_ok_ff;

   ntcrt_delay #(.WIDTH($bits(ntcrt_pkg::tail_type)), .DEPTH(ntcrt_pkg::DIV_STAGES)) u_tail (
      .clock(clock), .reset(reset), .en(en), .d_in(tail_in), .d_out(tail_d)
   );

   always_comb begin
      tsh_in = (!tail_d.zero && tail_d.sh_ok) ? to_centi(q_sh, ovf_sh) : 18'sd0;
      tb_in  = (!tail_d.zero && tail_d.b_ok) ? to_centi(q_b, ovf_b) : 18'sd0;
      dif_in = {tsh_in[17], tsh_in} - {tb_in[17], tb_in};
      if (tail_d.zero || !tail_d.sh_ok || !tail_d.b_ok) begin
         diff_in = '0;
      end else if (dif_in > ntcrt_pkg::DIFF_LIM) begin
         diff_in = 16'(ntcrt_pkg::DIFF_LIM);
      end else if (dif_in < -ntcrt_pkg::DIFF_LIM) begin
         diff_in = 16'(-ntcrt_pkg::DIFF_LIM);
      end else begin
         diff_in = dif_in[15:0];
      end
      priority if (tail_d.zero) begin
         status_in = ntcrt_pkg::ST_ZERO;
      end else if (!tail_d.sh_ok) begin
         status_in = ntcrt_pkg::ST_SH_BAD;
      end else if (!tail_d.b_ok) begin
         status_in = ntcrt_pkg::ST_BETA_BAD;
      end else begin
         status_in = ntcrt_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tail_d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tsh_ff    <= tsh_in;
         tb_ff     <= tb_in;
         diff_ff   <= diff_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_temp_sh_centi    = tsh_ff;
   assign rsp_temp_beta_centi  = tb_ff;
   assign rsp_model_difference = diff_ff;
   assign rsp_status           = status_ff;

endmodule

>>> design/ntcrt_checker.sv
// port-level checks on the result channel, bound to the top level
module ntcrt_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [17:0] rsp_temp_sh_centi,
   input logic signed [17:0] rsp_temp_beta_centi,
   input logic signed [15:0] rsp_model_difference,
   input logic [1:0]         rsp_status
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp_sh_centi)
         && $stable(rsp_temp_beta_centi) && $stable(rsp_model_difference)
         && $stable(rsp_status))
      else $error("stalled result beat changed");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ntcrt_pkg::ST_ZERO |-> rsp_temp_sh_centi == 18'sd0
         && rsp_temp_beta_centi == 18'sd0 && rsp_model_difference == 16'sd0)
      else $error("zero resistance beat carries a temperature");

   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ntcrt_pkg::ST_SH_BAD || rsp_status == ntcrt_pkg::ST_BETA_BAD)
         |-> rsp_model_difference == 16'sd0)
      else $error("difference reported with a bad denominator");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temp_sh_centi >= -18'sd27315 && rsp_temp_sh_centi <= 18'sd100000
         && rsp_temp_beta_centi >= -18'sd27315 && rsp_temp_beta_centi <= 18'sd100000
         && rsp_model_difference >= -16'sd20000 && rsp_model_difference <= 16'sd20000)
      else $error("result beat out of range");

endmodule

bind ntc_resistance_to_temperature ntcrt_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_temp_sh_centi(rsp_temp_sh_centi),
   .rsp_temp_beta_centi(rsp_temp_beta_centi),
   .rsp_model_difference(rsp_model_difference),
   .rsp_status(rsp_status)
);

>>> tb/sv/tb.sv
// testbench for ntc_resistance_to_temperature: directed and random beats against a predictor
`timescale 1ns / 1ps

module tb;

   localparam int          LOG_F      = 24;
   localparam int          LATENCY    = LOG_F + 35;
   localparam int          IDLE_LIMIT = 5000;
   localparam logic [2:0]  CSR_UNUSED = 3'd6;
   localparam logic [63:0] SAT_MAG    = 64'h2000_0000_0000_0000;
   localparam logic [55:0] S56_MAX    = 56'h7F_FFFF_FFFF_FFFF;
   localparam logic [55:0] S56_MIN    = 56'h80_0000_0000_0000;
   localparam logic [54:0] U55_MAX    = 55'h7F_FFFF_FFFF_FFFF;
   localparam logic [28:0] U29_MAX    = 29'h1FFF_FFFF;

   typedef struct {
      logic signed [17:0]    temp_sh;
      logic signed [17:0]    temp_beta;
      logic signed [15:0]    difference;
      ntcrt_pkg::status_type status;
   } temps_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [23:0] req_resistance_ohm;
   logic        rsp_valid;
   logic        rsp_ready;
   logic signed [17:0] rsp_temp_sh_centi;
   logic signed [17:0] rsp_temp_beta_centi;
   logic signed [15:0] rsp_model_difference;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [ntcrt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ntcrt_pkg::CSR_DATA_W-1:0]  csr_data;

   logic [55:0] a_reg, b_reg, c_reg;
   logic [54:0] inv_t_ref_reg, inv_beta_reg;
   logic [28:0] ln_r_ref_reg;

   temps_type expected_temps[$];
   int  n_beats, n_results, n_errors, idle_cycles;
   int  status_seen[4];
   bit  hold_rsp, no_stall;

   ntc_resistance_to_temperature uut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // fixed-point arithmetic of the conversion
   function automatic logic [63:0] mul_trunc_sat(logic [63:0] x, logic [63:0] y);
      logic [127:0] p;
      logic [63:0]  r;
      p = {64'd0, x} * {64'd0, y};
      if (p[127:64+LOG_F] != 0) return SAT_MAG;
      r = p[63+LOG_F:LOG_F];
      return (r > SAT_MAG) ? SAT_MAG : r;
   endfunction

   function automatic logic [63:0] ln_fixed(logic [23:0] r);
      int           e;
      logic [63:0]  x, frac;
      logic [127:0] p;
      e = 0;
      for (int i = 0; i < 24; i++) if (r[i]) e = i;
      x = 64'(r) << (31 - e);
      frac = 0;
      for (int i = 0; i < LOG_F; i++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            x = x >> 1;
         end
      end
      p = {64'd0, (64'(e) << LOG_F) | frac} * {64'd0, ntcrt_pkg::LN2_Q64};
      return p[127:64];
   endfunction

   function automatic longint apply_sign(logic [63:0] mag, bit neg);
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [17:0] centi_from_denom(longint d);
      logic [63:0] ud, q;
      ud = d;
      q = (ntcrt_pkg::CENTI_NUM + ud / 2) / ud;
      if (q > 64'(ntcrt_pkg::Q_MAX)) return ntcrt_pkg::TEMP_MAX;
      return 18'(q) - ntcrt_pkg::KELVIN_CENTI;
   endfunction

   function automatic temps_type convert_resistance(logic [23:0] r);
      temps_type   t;
      logic [63:0] l, l3, amag, bmag, cmag, dmag, refq;
      bit          dn;
      longint      dsh, db, diff;
      t.temp_sh = 0;
      t.temp_beta = 0;
      t.difference = 0;
      t.status = ntcrt_pkg::ST_OK;
      if (r == 0) begin
         t.status = ntcrt_pkg::ST_ZERO;
         return t;
      end
      l = ln_fixed(r);
      l3 = mul_trunc_sat(mul_trunc_sat(l, l), l);
      amag = a_reg[55] ? 64'(56'(-a_reg)) : 64'(a_reg);
      bmag = b_reg[55] ? 64'(56'(-b_reg)) : 64'(b_reg);
      cmag = c_reg[55] ? 64'(56'(-c_reg)) : 64'(c_reg);
      dsh = apply_sign(amag, a_reg[55]) + apply_sign(mul_trunc_sat(bmag, l), b_reg[55])
          + apply_sign(mul_trunc_sat(cmag, l3), c_reg[55]);
      refq = 64'(ln_r_ref_reg) << (LOG_F - 24);
      dn = refq > l;
      dmag = dn ? refq - l : l - refq;
      db = longint'(64'(inv_t_ref_reg))
         + apply_sign(mul_trunc_sat(64'(inv_beta_reg), dmag), dn);
      if (dsh > 0) t.temp_sh = centi_from_denom(dsh);
      if (db > 0) t.temp_beta = centi_from_denom(db);
      if (dsh <= 0) begin
         t.status = ntcrt_pkg::ST_SH_BAD;
         t.temp_sh = 0;
      end else if (db <= 0) begin
         t.status = ntcrt_pkg::ST_BETA_BAD;
      end else begin
         diff = longint'(t.temp_sh) - longint'(t.temp_beta);
         if (diff > ntcrt_pkg::DIFF_LIM) diff = ntcrt_pkg::DIFF_LIM;
         if (diff < -ntcrt_pkg::DIFF_LIM) diff = -ntcrt_pkg::DIFF_LIM;
         t.difference = 16'(diff);
      end
      return t;
   endfunction

   function automatic int pick_gap();
      int k;
      if (no_stall) return 0;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_resistance(logic [23:0] r);
      int gap;
      bit ok;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_resistance_ohm <= r;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
      expected_temps.push_back(convert_resistance(r));
      n_beats++;
   endtask

   task automatic csr_put(logic [2:0] idx, logic [55:0] value);
      bit ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      case (idx)
         ntcrt_pkg::CSR_A_COEF:    a_reg = value;
         ntcrt_pkg::CSR_B_COEF:    b_reg = value;
         ntcrt_pkg::CSR_C_COEF:    c_reg = value;
         ntcrt_pkg::CSR_INV_T_REF: inv_t_ref_reg = value[54:0];
         ntcrt_pkg::CSR_INV_BETA:  inv_beta_reg = value[54:0];
         ntcrt_pkg::CSR_LN_R_REF:  ln_r_ref_reg = value[28:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_temps.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic load_coefficients(logic [55:0] a, logic [55:0] b, logic [55:0] c,
                                    logic [54:0] itr, logic [54:0] ib, logic [28:0] lr);
      wait_drained();
      csr_put(ntcrt_pkg::CSR_A_COEF, a);
      csr_put(ntcrt_pkg::CSR_B_COEF, b);
      csr_put(ntcrt_pkg::CSR_C_COEF, c);
      csr_put(ntcrt_pkg::CSR_INV_T_REF, 56'(itr));
      csr_put(ntcrt_pkg::CSR_INV_BETA, 56'(ib));
      csr_put(ntcrt_pkg::CSR_LN_R_REF, 56'(lr));
      csr_put(CSR_UNUSED, 56'({$urandom, $urandom}));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [55:0] scaled(real v, real spread);
      real s;
      s = 1.0 + spread * ($urandom_range(0, 20000) - 10000) / 10000.0;
      return 56'(longint'(v * s * (2.0 ** 52)));
   endfunction

   task automatic load_typical(real spread);
      load_coefficients(scaled(1.129148e-3, spread), scaled(2.34125e-4, spread),
                        scaled(8.76741e-8, spread), 55'(scaled(1.0 / 298.15, spread)),
                        55'(scaled(1.0 / 3950.0, spread)),
                        29'(longint'($ln(10000.0) * (2.0 ** 24))));
   endtask

   function automatic logic [23:0] random_resistance();
      logic [23:0] r;
      r = 24'($urandom);
      case ($urandom_range(0, 3))
         0: return r;
         1: return r >> $urandom_range(0, 23);
         2: return 24'($urandom_range(1000, 200000));
         default: return 24'($urandom_range(0, 3000));
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_resistance(24'd10000);
      send_resistance(24'd0);
      send_resistance(24'hFF_FFFF);
   endtask

   task automatic test_directed_typical();
      load_typical(0.0);
      send_resistance(24'd0);
      send_resistance(24'd1);
      send_resistance(24'd2);
      send_resistance(24'd10000);
      send_resistance(24'h80_0000);
      send_resistance(24'hFF_FFFF);
      send_resistance(24'h55_5555);
      send_resistance(24'hAA_AAAA);
      send_resistance(24'd33);
   endtask

   task automatic test_special_cases();
      // steinhart-hart denominator negative, beta still good
      load_coefficients(S56_MIN, 56'd0, 56'd0, 55'(scaled(1.0 / 298.15, 0.0)),
                        55'(scaled(1.0 / 3950.0, 0.0)), 29'd154_000_000);
      send_resistance(24'd10000);
      send_resistance(24'd1);
      // beta denominator negative
      load_coefficients(scaled(1.129148e-3, 0.0), scaled(2.34125e-4, 0.0),
                        scaled(8.76741e-8, 0.0), 55'd0, U55_MAX, U29_MAX);
      send_resistance(24'd1);
      send_resistance(24'd500);
      // both bad, and saturating terms
      load_coefficients(S56_MIN, S56_MIN, S56_MIN, 55'd0, U55_MAX, U29_MAX);
      send_resistance(24'd2);
      send_resistance(24'hFF_FFFF);
      // tiny denominators push the temperature to its ceiling
      load_coefficients(56'd1, 56'd0, 56'd0, 55'd1, 55'd0, 29'd0);
      send_resistance(24'd7);
      send_resistance(24'hFF_FFFF);
      load_coefficients(S56_MAX, S56_MAX, S56_MAX, U55_MAX, U55_MAX, 29'd0);
      send_resistance(24'hFF_FFFF);
      send_resistance(24'd1);
   endtask

   task automatic test_random(int count, int mode);
      case (mode)
         0: load_typical(0.05);
         1: load_typical(0.6);
         2: load_coefficients(56'({$urandom, $urandom}), 56'({$urandom, $urandom}),
                              56'({$urandom, $urandom}), 55'({$urandom, $urandom}),
                              55'({$urandom, $urandom}), 29'($urandom));
         3: load_coefficients(scaled(1.1e-3, 0.3), scaled(2.3e-4, 0.3), -scaled(9e-8, 0.5),
                              55'(scaled(1.0 / 298.15, 0.3)), 55'({$urandom, $urandom} >> 14),
                              29'($urandom));
         default: load_coefficients(56'd0, 56'd0, 56'd0, 55'd0, 55'd0, 29'd0);
      endcase
      for (int i = 0; i < count; i++) send_resistance(random_resistance());
   endtask

   task automatic test_back_pressure();
      wait_drained();
      no_stall = 1;
      hold_rsp = 1;
      for (int i = 0; i < 150; i++) send_resistance(random_resistance());
      no_stall = 0;
   endtask

   // result side ready
   initial begin
      int k;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
            rsp_ready <= 1'b1;
         end else if (!no_stall && $urandom_range(0, 99) < 25) begin
            k = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
            rsp_ready <= 1'b0;
            repeat (k) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // result checking
   initial begin
      temps_type t;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            n_results++;
            if (expected_temps.size() == 0) begin
               $display("%0t: result beat with nothing expected", $time);
               n_errors++;
            end else begin
               t = expected_temps.pop_front();
               status_seen[t.status]++;
               if (rsp_temp_sh_centi !== t.temp_sh) begin
                  $display("%0t: temp_sh expected %0d actual %0d", $time, t.temp_sh,
                           rsp_temp_sh_centi);
                  n_errors++;
               end
               if (rsp_temp_beta_centi !== t.temp_beta) begin
                  $display("%0t: temp_beta expected %0d actual %0d", $time, t.temp_beta,
                           rsp_temp_beta_centi);
                  n_errors++;
               end
               if (rsp_model_difference !== t.difference) begin
                  $display("%0t: difference expected %0d actual %0d", $time, t.difference,
                           rsp_model_difference);
                  n_errors++;
               end
               if (rsp_status !== t.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, t.status, rsp_status);
                  n_errors++;
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      idle_cycles = 0;
      forever begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("** ntc_resistance_to_temperature: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_resistance_ohm = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      a_reg = 0; b_reg = 0; c_reg = 0;
      inv_t_ref_reg = 0; inv_beta_reg = 0; ln_r_ref_reg = 0;
      hold_rsp = 0;
      no_stall = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_typical();
      test_special_cases();
      test_random(300, 0);
      test_random(200, 1);
      test_random(200, 2);
      test_random(150, 3);
      test_back_pressure();
      no_stall = 1;
      test_random(80, 0);
      no_stall = 0;
      test_random(60, 4);
      wait_drained();
      $display("%0d resistance beats sent, %0d results checked, %0d mismatches",
               n_beats, n_results, n_errors);
      $display("status mix ok/zero/sh-bad/beta-bad: %0d/%0d/%0d/%0d", status_seen[0],
               status_seen[1], status_seen[2], status_seen[3]);
      if (n_errors == 0)
         $display("** ntc_resistance_to_temperature: PASSED **");
      else
         $display("** ntc_resistance_to_temperature: FAILED **");
      $finish;
   end

endmodule

>>> ntc_resistance_to_temperature.f
design/ntcrt_pkg.sv
design/ntcrt_delay.sv
design/ntcrt_log2.sv
design/ntcrt_mul.sv
design/ntcrt_div.sv
design/ntc_resistance_to_temperature.sv
design/ntcrt_checker.sv
tb/sv/tb.sv
